// ----- src/rac_pkg.sv -----
// Shared types and constants for the refcounted attribute cache.
// Entry layout, request and status codes; used by the cache unit.
package rac_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] REQ_GET   = 3'd0;
  localparam logic [2:0] REQ_PUT   = 3'd1;
  localparam logic [2:0] REQ_CHECK = 3'd2;
  localparam logic [2:0] REQ_STAMP = 3'd3;
  localparam logic [2:0] REQ_PIN   = 3'd4;

  typedef enum logic [3:0] {
    ST_HIT        = 4'd0,
    ST_ALLOCATED  = 4'd1,
    ST_FULL       = 4'd2,
    ST_RELEASED   = 4'd3,
    ST_PUT_UNUSED = 4'd4,
    ST_PUT_PINNED = 4'd5,
    ST_FRESH      = 4'd6,
    ST_STALE      = 4'd7,
    ST_DONE       = 4'd8
  } status_t;

  typedef struct packed {
    logic [15:0] key_device;
    logic [31:0] key_inode;
    logic        in_use;
    logic [15:0] refs;
    logic        pinned;
    logic [31:0] stamp_sec;
    logic [19:0] stamp_usec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/rac_if.sv -----
// Handshake channels of the refcounted attribute cache: request, response
// and configuration write. Depends on nothing.
interface rac_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] dev_id;
  logic [31:0]        inode;
  logic [5:0]         slot;
  logic [31:0]        now_sec;
  logic [19:0]        now_usec;
  modport source (output valid, req_type, dev_id, inode, slot, now_sec, now_usec,
                  input ready);
  modport sink   (input valid, req_type, dev_id, inode, slot, now_sec, now_usec,
                  output ready);
endinterface

interface rac_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [5:0]  result_slot;
  logic [15:0] ref_count;
  modport source (output valid, status, result_slot, ref_count, input ready);
  modport sink   (input valid, status, result_slot, ref_count, output ready);
endinterface

interface rac_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/refcounted_attribute_cache_unit.sv -----
// Reference-counted attribute cache keyed by (device, inode). One request at a
// time. A get walks the entry RAM one entry per cycle looking for the first key
// match while tracking the oldest free entry, and ends at a hit or after the
// last entry; put, check, stamp and pin read a single entry, and all but check
// may write it back. The next request is taken in the cycle after the response
// is registered. The single-read-port entry RAM sets this pace. Entries read as
// all zero until first written (per entry valid flops, no clearing pass). A
// finished response sits in an output register, so a new request is taken
// while it waits.
// Depends on rac_pkg, rac_if.sv and rac_ram.
module refcounted_attribute_cache_unit (
  input  logic clk,
  input  logic rst,
  rac_req_if.sink   req,
  rac_rsp_if.source rsp,
  rac_cfg_if.sink   cfg
);

  localparam int IW = rac_pkg::IDX_W;
  localparam int ENTRIES_W = rac_pkg::ENTRIES;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [15:0] stale_timeout_sec;

  // latched request
  logic [2:0]  q_type;
  logic [15:0] q_dev;
  logic [31:0] q_inode;
  logic [31:0] q_sec;
  logic [19:0] q_usec;

  // RAM access
  logic [IW-1:0]          rd_idx;
  logic [IW-1:0]          dat_idx;
  logic                   dat_vld;
  logic                   vld_q;
  logic [rac_pkg::ENTRY_W-1:0] rd_data;
  logic [ENTRIES_W-1:0]   valid;
  rac_pkg::entry_t        ent;

  // scan tracking
  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_sec;
  logic [19:0]   best_usec;

  // pending write and result
  logic            wr_pend;
  logic [IW-1:0]   wr_idx;
  rac_pkg::entry_t wr_ent;
  logic [3:0]      res_status;
  logic [5:0]      res_slot;
  logic [15:0]     res_count;

  logic            out_valid;
  logic [3:0]      out_status;
  logic [5:0]      out_slot;
  logic [15:0]     out_count;

  // updated entry images
  rac_pkg::entry_t hit_ent;
  rac_pkg::entry_t alloc_ent;
  rac_pkg::entry_t exec_ent;
  logic            exec_wr;
  logic [3:0]      exec_status;
  logic [15:0]     exec_count;

  logic            accept;
  logic            release_out;
  logic            do_write;
  logic            slot_ok;
  logic [IW-1:0]   slot_idx;
  logic            key_match;
  logic            is_older;
  logic            is_last;
  logic [15:0]     refs_inc;
  logic [15:0]     refs_dec;
  logic signed [33:0] age;
  logic            stale;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign release_out = (state == S_DONE) && (!out_valid || rsp.ready);
  assign do_write    = release_out && wr_pend;

  assign slot_ok  = 32'(req.slot) < rac_pkg::ENTRIES;
  assign slot_idx = IW'(req.slot);

  rac_ram #(
    .WIDTH(rac_pkg::ENTRY_W),
    .DEPTH(rac_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(wr_idx),
    .wdata(wr_ent),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  // never-written entries read as zero
  assign ent = vld_q ? rac_pkg::entry_t'(rd_data) : '0;

  assign key_match = (ent.key_device == q_dev) && (ent.key_inode == q_inode);
  assign is_older  = !ent.in_use &&
                     ({ent.stamp_sec, ent.stamp_usec} < {best_sec, best_usec});
  assign is_last   = (dat_idx == IW'(rac_pkg::ENTRIES - 1));
  assign refs_inc  = (ent.refs == 16'hFFFF) ? ent.refs : ent.refs + 16'd1;
  assign refs_dec  = (ent.refs == 16'd0) ? ent.refs : ent.refs - 16'd1;

  // elapsed seconds with borrow from the microseconds part
  assign age = $signed({2'b00, q_sec}) - $signed({2'b00, ent.stamp_sec})
             - ((q_usec < ent.stamp_usec) ? 34'sd1 : 34'sd0);
  assign stale = ((ent.stamp_sec == 32'd0) && (ent.stamp_usec == 20'd0)) ||
                 (age > $signed({18'd0, stale_timeout_sec}));

  always_comb begin
    hit_ent        = ent;
    hit_ent.in_use = 1'b1;
    hit_ent.refs   = refs_inc;

    alloc_ent            = '0;
    alloc_ent.key_device = q_dev;
    alloc_ent.key_inode  = q_inode;
    alloc_ent.in_use     = 1'b1;
    alloc_ent.refs       = 16'd1;

    exec_ent    = ent;
    exec_wr     = 1'b0;
    exec_status = rac_pkg::ST_DONE;
    exec_count  = ent.refs;
    case (q_type)
      rac_pkg::REQ_PUT: begin
        if (!ent.in_use) begin
          exec_status = rac_pkg::ST_PUT_UNUSED;
        end else if (ent.pinned && (ent.refs == 16'd1)) begin
          exec_status = rac_pkg::ST_PUT_PINNED;
        end else begin
          exec_wr         = 1'b1;
          exec_ent.refs   = refs_dec;
          exec_ent.in_use = (refs_dec != 16'd0);
          exec_status     = rac_pkg::ST_RELEASED;
          exec_count      = refs_dec;
        end
      end
      rac_pkg::REQ_CHECK: begin
        exec_status = stale ? rac_pkg::ST_STALE : rac_pkg::ST_FRESH;
      end
      rac_pkg::REQ_STAMP: begin
        exec_wr             = 1'b1;
        exec_ent.stamp_sec  = q_sec;
        exec_ent.stamp_usec = q_usec;
      end
      rac_pkg::REQ_PIN: begin
        exec_wr         = 1'b1;
        exec_ent.pinned = 1'b1;
      end
      default: begin
        exec_status = rac_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout_sec <= '0;
    end else if (cfg.valid && cfg.ready) begin
      stale_timeout_sec <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    vld_q   <= valid[rd_idx];
    dat_idx <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
      dat_vld   <= 1'b0;
      rd_idx    <= '0;
    end else begin
      dat_vld <= (state == S_SCAN);
      if (do_write) begin
        valid[wr_idx] <= 1'b1;
      end
      if (release_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == rac_pkg::REQ_GET) begin
              rd_idx <= '0;
              state  <= S_SCAN;
            end else if (slot_ok) begin
              rd_idx <= slot_idx;
              state  <= S_FETCH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + 1'b1;
          if (dat_vld && (key_match || is_last)) begin
            state <= S_DONE;
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC:  state <= S_DONE;
        S_DONE: begin
          if (release_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: request latch, scan tracking, result and write staging
  always_ff @(posedge clk) begin
    if (release_out) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_count  <= res_count;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          q_type     <= req.req_type;
          q_dev      <= $unsigned(req.dev_id);
          q_inode    <= req.inode;
          q_sec      <= req.now_sec;
          q_usec     <= req.now_usec;
          best_found <= 1'b0;
          best_idx   <= '0;
          best_sec   <= req.now_sec;
          best_usec  <= req.now_usec;
          wr_pend    <= 1'b0;
          res_status <= rac_pkg::ST_DONE;
          res_slot   <= req.slot;
          res_count  <= '0;
        end
      end
      S_SCAN: begin
        if (dat_vld) begin
          if (key_match) begin
            wr_pend    <= 1'b1;
            wr_idx     <= dat_idx;
            wr_ent     <= hit_ent;
            res_status <= rac_pkg::ST_HIT;
            res_slot   <= 6'(dat_idx);
            res_count  <= refs_inc;
          end else begin
            if (is_older) begin
              best_found <= 1'b1;
              best_idx   <= dat_idx;
              best_sec   <= ent.stamp_sec;
              best_usec  <= ent.stamp_usec;
            end
            if (is_last) begin
              if (best_found || is_older) begin
                wr_pend    <= 1'b1;
                wr_idx     <= is_older ? dat_idx : best_idx;
                wr_ent     <= alloc_ent;
                res_status <= rac_pkg::ST_ALLOCATED;
                res_slot   <= 6'(is_older ? dat_idx : best_idx);
                res_count  <= 16'd1;
              end else begin
                res_status <= rac_pkg::ST_FULL;
                res_slot   <= '0;
                res_count  <= '0;
              end
            end
          end
        end
      end
      S_EXEC: begin
        wr_idx     <= dat_idx;
        wr_ent     <= exec_ent;
        wr_pend    <= exec_wr;
        res_status <= exec_status;
        res_count  <= exec_count;
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.result_slot = out_slot;
  assign rsp.ref_count   = out_count;

endmodule

// ----- src/rac_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone, no package use.
module rac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
